>>> hdl/srwl_pkg.sv
package srwl_pkg;

  // Longest record in characters when no line feed arrives
  localparam int unsigned MAX_LINE_CHARS = 47;
  localparam logic [5:0]  LAST_POS       = 6'(MAX_LINE_CHARS - 1);

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_S  = 8'h53;

  localparam logic [7:0] DIGIT_BIAS = 8'd48;
  localparam logic [7:0] LOWER_BIAS = 8'd87;
  localparam logic [7:0] UPPER_BIAS = 8'd55;

  // Result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_NO_S  = 3'd1;
  localparam logic [2:0] ERR_HEX   = 3'd2;
  localparam logic [2:0] ERR_TYPE  = 3'd3;
  localparam logic [2:0] ERR_COUNT = 3'd4;

  // Record kinds as held internally
  localparam logic [2:0] REC_HEADER = 3'd0;
  localparam logic [2:0] REC_S1     = 3'd1;
  localparam logic [2:0] REC_S2     = 3'd2;
  localparam logic [2:0] REC_S3     = 3'd3;
  localparam logic [2:0] REC_S9     = 3'd4;
  localparam logic [2:0] REC_S8     = 3'd5;
  localparam logic [2:0] REC_S7     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_START = 2'd0;
  localparam logic [1:0] REG_WINDOW_END   = 2'd1;
  localparam logic [1:0] REG_DEST_OFFSET  = 2'd2;

  typedef struct packed {
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [31:0] dest_offset;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic [2:0]  error_code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] diff;
    h = '0;
    diff = '0;
    if (c >= "0" && c <= "9") begin
      diff = c - DIGIT_BIAS;
      h.ok = 1'b1;
    end else if (c >= "a" && c <= "f") begin
      diff = c - LOWER_BIAS;
      h.ok = 1'b1;
    end else if (c >= "A" && c <= "F") begin
      diff = c - UPPER_BIAS;
      h.ok = 1'b1;
    end
    h.nib = diff[3:0];
    return h;
  endfunction

  function automatic logic [2:0] addr_bytes(input logic [2:0] rec_kind);
    logic [2:0] n;
    n = 3'd2;
    if (rec_kind == REC_S2 || rec_kind == REC_S8) n = 3'd3;
    if (rec_kind == REC_S3 || rec_kind == REC_S7) n = 3'd4;
    return n;
  endfunction

endpackage

>>> hdl/srwl_if.sv
interface srwl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface srwl_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] write_address;
  logic [7:0]  write_byte;
  logic [2:0]  error_code;

  modport source (output valid, output kind, output write_address, output write_byte,
                  output error_code, input ready);
  modport sink (input valid, input kind, input write_address, input write_byte,
                input error_code, output ready);
endinterface

>>> hdl/srecord_window_loader.sv
// S-record loader: takes one ASCII character per request on char_chan and returns
// at most one result per character on result_chan: a data write (address and byte)
// for each data byte of an S1/S2/S3 record lying wholly inside the configured window,
// a done result at the end of the first S7/S8/S9 record, or an error code; after done
// or an error the block ignores further characters until reset. It sustains one
// character per clock cycle while result_chan.ready takes each result; the input
// register feeds the parse logic straight into the result register. A result held
// by result_chan.ready holds the input too.
// Write window_start, window_end and dest_offset only while no character is in flight.
module srecord_window_loader
  import srwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  srwl_char_if.sink            char_chan,
  srwl_result_if.source        result_chan
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_char;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid;
  result_t    out_res;

  // Move a character through the parser when the result slot is free or draining
  assign advance         = in_valid && (!out_valid || result_chan.ready);
  assign char_chan.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start <= '0;
      cfg.window_end   <= '1;
      cfg.dest_offset  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_START: cfg.window_start <= cfg_data;
        REG_WINDOW_END:   cfg.window_end   <= cfg_data;
        REG_DEST_OFFSET:  cfg.dest_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_chan.valid && char_chan.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_chan.valid && char_chan.ready) begin
      in_char <= char_chan.char_in;
    end
  end

  srwl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .c         (in_char),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result_chan.valid         = out_valid;
  assign result_chan.kind          = out_res.kind;
  assign result_chan.write_address = out_res.write_address;
  assign result_chan.write_byte    = out_res.write_byte;
  assign result_chan.error_code    = out_res.error_code;

endmodule

>>> hdl/srwl_parser.sv
module srwl_parser
  import srwl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] c,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  logic [5:0]  char_position, char_position_next;
  logic [2:0]  record_kind, record_kind_next;
  logic [4:0]  data_count, data_count_next;
  logic [31:0] record_address, record_address_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [3:0]  count_high, count_high_next;
  logic [4:0]  data_index, data_index_next;
  logic        in_window, in_window_next;
  logic        halted, halted_next;

  hex_t        hx;
  logic [2:0]  ab;
  logic [5:0]  dstart;
  logic [5:0]  fend;
  logic [5:0]  fend_cur;
  logic        known;
  logic [7:0]  raw;
  logic [7:0]  count_rest;
  logic        count_ok;
  logic [31:0] addr_shift;
  logic [31:0] write_addr;
  logic        err;
  logic [2:0]  err_code;
  logic        wr;
  logic        done;

  assign hx         = hex_decode(c);
  assign ab         = addr_bytes(record_kind);
  assign dstart     = 6'd4 + {2'b00, ab, 1'b0};
  assign fend       = dstart + {data_count, 1'b0};
  assign known      = char_position >= 6'd4;
  assign raw        = {count_high, hx.nib};
  assign count_rest = raw - {5'b0, ab} - 8'd1;
  assign count_ok   = (raw >= ({5'b0, ab} + 8'd1)) && (count_rest <= 8'd16);
  assign addr_shift = {record_address[27:0], hx.nib};
  assign write_addr = record_address - cfg.window_start + cfg.dest_offset
                      + {27'b0, data_index};

  always_comb begin
    char_position_next  = char_position;
    record_kind_next    = record_kind;
    data_count_next     = data_count;
    record_address_next = record_address;
    high_nibble_next    = high_nibble;
    count_high_next     = count_high;
    data_index_next     = data_index;
    in_window_next      = in_window;
    halted_next         = halted;
    fend_cur            = fend;
    err                 = 1'b0;
    err_code            = ERR_NONE;
    wr                  = 1'b0;
    done                = 1'b0;

    if (step && !halted) begin
      if (char_position == 6'd0) begin
        if (c != CH_S) begin
          err      = 1'b1;
          err_code = ERR_NO_S;
        end else begin
          record_kind_next    = REC_HEADER;
          data_count_next     = '0;
          record_address_next = '0;
          high_nibble_next    = '0;
          count_high_next     = '0;
          data_index_next     = '0;
          in_window_next      = 1'b0;
          char_position_next  = 6'd1;
        end
      end else if (char_position == 6'd1) begin
        char_position_next = 6'd2;
        case (c)
          "0": record_kind_next = REC_HEADER;
          "1": record_kind_next = REC_S1;
          "2": record_kind_next = REC_S2;
          "3": record_kind_next = REC_S3;
          "9": record_kind_next = REC_S9;
          "8": record_kind_next = REC_S8;
          "7": record_kind_next = REC_S7;
          default: begin
            err      = 1'b1;
            err_code = ERR_TYPE;
          end
        endcase
      end else if (known && char_position >= fend) begin
        // checksum and trailing characters are skipped
        if (c == CH_LF || char_position >= LAST_POS) begin
          char_position_next = '0;
          done               = record_kind >= REC_S9;
        end else begin
          char_position_next = char_position + 6'd1;
        end
      end else if (!hx.ok) begin
        err      = 1'b1;
        err_code = ERR_HEX;
      end else begin
        if (char_position == 6'd2) begin
          count_high_next = hx.nib;
        end else if (char_position == 6'd3) begin
          if (!count_ok) begin
            err      = 1'b1;
            err_code = ERR_COUNT;
          end else begin
            data_count_next = count_rest[4:0];
            fend_cur        = dstart + {count_rest[4:0], 1'b0};
          end
        end else if (char_position < dstart) begin
          record_address_next = addr_shift;
          if (char_position == dstart - 6'd1) begin
            in_window_next = record_kind >= REC_S1 && record_kind <= REC_S3
                             && addr_shift >= cfg.window_start
                             && ({1'b0, addr_shift} + {28'b0, data_count})
                                <= {1'b0, cfg.window_end};
          end
        end else if (!char_position[0]) begin
          high_nibble_next = hx.nib;
        end else begin
          wr              = in_window;
          data_index_next = data_index + 5'd1;
        end

        if (!err) begin
          if (char_position >= LAST_POS) begin
            // cut off by length before all digits arrived
            if (({1'b0, char_position} + 7'd1) < {1'b0, fend_cur}) begin
              err      = 1'b1;
              err_code = ERR_COUNT;
            end else begin
              char_position_next = '0;
              done               = record_kind >= REC_S9 && !wr;
            end
          end else begin
            char_position_next = char_position + 6'd1;
          end
        end
      end
    end

    res_valid = 1'b0;
    res       = '0;
    if (err) begin
      halted_next    = 1'b1;
      res_valid      = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = err_code;
    end else if (wr) begin
      res_valid         = 1'b1;
      res.kind          = KIND_WRITE;
      res.write_address = write_addr;
      res.write_byte    = {high_nibble, hx.nib};
    end else if (done) begin
      halted_next = 1'b1;
      res_valid   = 1'b1;
      res.kind    = KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position  <= '0;
      record_kind    <= '0;
      data_count     <= '0;
      record_address <= '0;
      high_nibble    <= '0;
      count_high     <= '0;
      data_index     <= '0;
      in_window      <= 1'b0;
      halted         <= 1'b0;
    end else begin
      char_position  <= char_position_next;
      record_kind    <= record_kind_next;
      data_count     <= data_count_next;
      record_address <= record_address_next;
      high_nibble    <= high_nibble_next;
      count_high     <= count_high_next;
      data_index     <= data_index_next;
      in_window      <= in_window_next;
      halted         <= halted_next;
    end
  end

endmodule

>>> tb/srecord_window_loader_tb.sv
module srecord_window_loader_tb;
  import srwl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LINE_LAST   = MAX_LINE_CHARS - 1;

  typedef enum {END_LF, END_JUNK_LF, END_FULL_LINE} line_end_e;
  typedef enum {ADDR_ANY, ADDR_NEAR_START, ADDR_AT_END, ADDR_PAST_END, ADDR_BELOW_START} addr_mode_e;
  typedef enum {
    STOP_END_RECORD, STOP_NO_S, STOP_BAD_TYPE, STOP_BAD_HEX, STOP_COUNT_LOW, STOP_COUNT_HIGH
  } stop_case_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  srwl_char_if   char_chan ();
  srwl_result_if result_chan ();

  srecord_window_loader uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_chan   (char_chan),
    .result_chan (result_chan)
  );

  always #5 clk = ~clk;

  // Register copies and parser state of the loader
  logic [31:0] win_start  = 32'h0;
  logic [31:0] win_end    = 32'hFFFF_FFFF;
  logic [31:0] dst_offset = 32'h0;

  logic [5:0]  cur_pos       = '0;
  logic [2:0]  cur_kind      = REC_HEADER;
  logic [4:0]  cur_count     = '0;
  logic [31:0] cur_addr      = '0;
  logic [3:0]  cur_hi        = '0;
  logic [3:0]  cur_count_hi  = '0;
  logic [4:0]  cur_index     = '0;
  bit          cur_in_window = 1'b0;
  bit          parser_halted = 1'b0;

  result_t     results_due[$];
  logic [7:0]  pending_chars[$];
  result_t     predicted;
  result_t     want;

  int unsigned errors      = 0;
  int unsigned chars_sent  = 0;
  int unsigned cycle_count = 0;
  bit          src_quiet   = 1'b0;
  int          stall_left  = 0;
  int          quiet_left  = 0;

  function automatic int addr_len(input logic [2:0] k);
    case (k)
      REC_S2, REC_S8: return 3;
      REC_S3, REC_S7: return 4;
      default:        return 2;
    endcase
  endfunction

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] n);
    n = '0;
    if (c >= "0" && c <= "9") n = 4'(c - "0");
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit stop_with(input logic [2:0] code, output result_t r);
    parser_halted = 1'b1;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  function automatic bit end_of_record(input bit wrote, inout result_t r);
    cur_pos = '0;
    if (cur_kind >= REC_S9 && !wrote) begin
      parser_halted = 1'b1;
      r = '0;
      r.kind = KIND_DONE;
      return 1'b1;
    end
    return wrote;
  endfunction

  // Advance the parser by one character; returns 1 when it yields a result
  function automatic bit parse_char(input logic [7:0] c, output result_t r);
    int unsigned p, ab, dstart, fend, raw;
    logic [3:0] nib;
    bit wrote;
    r = '0;
    wrote = 1'b0;
    if (parser_halted) return 1'b0;
    p = 32'(cur_pos);
    if (p == 0) begin
      if (c != CH_S) return stop_with(ERR_NO_S, r);
      cur_kind = REC_HEADER;
      cur_count = '0;
      cur_addr = '0;
      cur_hi = '0;
      cur_count_hi = '0;
      cur_index = '0;
      cur_in_window = 1'b0;
      cur_pos = 6'd1;
      return 1'b0;
    end
    if (p == 1) begin
      case (c)
        "0":     cur_kind = REC_HEADER;
        "1":     cur_kind = REC_S1;
        "2":     cur_kind = REC_S2;
        "3":     cur_kind = REC_S3;
        "9":     cur_kind = REC_S9;
        "8":     cur_kind = REC_S8;
        "7":     cur_kind = REC_S7;
        default: return stop_with(ERR_TYPE, r);
      endcase
      cur_pos = 6'd2;
      return 1'b0;
    end
    ab = addr_len(cur_kind);
    dstart = 4 + 2 * ab;
    fend = dstart + 2 * cur_count;
    if (p >= 4 && p >= fend) begin
      // checksum and anything after it pass unchecked
      if (c == CH_LF || p >= LINE_LAST) return end_of_record(1'b0, r);
      cur_pos = 6'(p + 1);
      return 1'b0;
    end
    if (!hex_nibble(c, nib)) return stop_with(ERR_HEX, r);
    if (p == 2) begin
      cur_count_hi = nib;
    end else if (p == 3) begin
      raw = 32'({cur_count_hi, nib});
      if (raw < ab + 1 || raw - ab - 1 > 16) return stop_with(ERR_COUNT, r);
      cur_count = 5'(raw - ab - 1);
      fend = dstart + 2 * cur_count;
    end else if (p < dstart) begin
      cur_addr = {cur_addr[27:0], nib};
      if (p == dstart - 1)
        cur_in_window = cur_kind >= REC_S1 && cur_kind <= REC_S3 && cur_addr >= win_start &&
                        ({1'b0, cur_addr} + 33'(cur_count)) <= {1'b0, win_end};
    end else if (((p - dstart) & 1) == 0) begin
      cur_hi = nib;
    end else begin
      if (cur_in_window) begin
        r.kind = KIND_WRITE;
        r.write_address = cur_addr - win_start + dst_offset + 32'(cur_index);
        r.write_byte = {cur_hi, nib};
        wrote = 1'b1;
      end
      cur_index = cur_index + 5'd1;
    end
    if (p >= LINE_LAST) begin
      if (p < 3 || p + 1 < fend) return stop_with(ERR_COUNT, r);
      return end_of_record(wrote, r);
    end
    cur_pos = 6'(p + 1);
    return wrote;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Predict on each accepted character, then check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (char_chan.valid && char_chan.ready) begin
        if (parse_char(char_chan.char_in, predicted)) results_due.push_back(predicted);
      end
      if (result_chan.valid && result_chan.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result kind %0d addr 0x%0h byte 0x%0h code %0d", $time,
                   result_chan.kind, result_chan.write_address, result_chan.write_byte,
                   result_chan.error_code);
          errors++;
        end else begin
          want = results_due.pop_front();
          compare_field("kind", 32'(want.kind), 32'(result_chan.kind));
          compare_field("write_address", want.write_address, result_chan.write_address);
          compare_field("write_byte", 32'(want.write_byte), 32'(result_chan.write_byte));
          compare_field("error_code", 32'(want.error_code), 32'(result_chan.error_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("srecord_window_loader: mismatch");
      $finish;
    end
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side stalls, with quiet stretches
  always @(negedge clk) begin
    if (quiet_left != 0) quiet_left--;
    else if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(40, 200);
    if (stall_left != 0) begin
      stall_left--;
      result_chan.ready <= 1'b0;
    end else if (quiet_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = gap_length();
      result_chan.ready <= (stall_left == 0);
    end else begin
      result_chan.ready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = src_quiet ? 0 : gap_length();
    if (gap > 0) begin
      @(negedge clk);
      char_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    char_chan.valid <= 1'b1;
    char_chan.char_in <= c;
    do @(posedge clk); while (!char_chan.ready);
    chars_sent++;
  endtask

  task automatic send_part(input int n);
    repeat (n) send_char(pending_chars.pop_front());
  endtask

  // Hold the sender until every result is in and the pipeline has drained
  task automatic wait_idle();
    @(negedge clk);
    char_chan.valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WINDOW_START: win_start  = val;
      REG_WINDOW_END:   win_end    = val;
      REG_DEST_OFFSET:  dst_offset = val;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return "0" + n;
    return ($urandom_range(0, 1) ? "a" : "A") + n - 8'd10;
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  task automatic push_hex_byte(input logic [7:0] b);
    pending_chars.push_back(hex_char(b[7:4]));
    pending_chars.push_back(hex_char(b[3:0]));
  endtask

  // Queue one record; fill < 0 gives random data bytes
  task automatic build_record(input logic [2:0] rk, input logic [31:0] addr, input int dc,
                              input int fill, input line_end_e ending);
    int ab, first, len;
    logic [7:0] type_ch;
    ab = addr_len(rk);
    first = pending_chars.size();
    case (rk)
      REC_S1:  type_ch = "1";
      REC_S2:  type_ch = "2";
      REC_S3:  type_ch = "3";
      REC_S9:  type_ch = "9";
      REC_S8:  type_ch = "8";
      REC_S7:  type_ch = "7";
      default: type_ch = "0";
    endcase
    pending_chars.push_back(CH_S);
    pending_chars.push_back(type_ch);
    push_hex_byte(8'(ab + 1 + dc));
    for (int i = ab - 1; i >= 0; i--) push_hex_byte(addr[8*i +: 8]);
    repeat (dc) push_hex_byte(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    push_hex_byte(8'($urandom_range(0, 255)));
    len = pending_chars.size() - first;
    case (ending)
      END_LF: pending_chars.push_back(CH_LF);
      END_JUNK_LF: begin
        repeat ($urandom_range(0, LINE_LAST - len)) pending_chars.push_back(junk_char());
        pending_chars.push_back(CH_LF);
      end
      default: repeat (MAX_LINE_CHARS - len) pending_chars.push_back(junk_char());
    endcase
  endtask

  task automatic rand_record();
    logic [2:0] rk;
    logic [31:0] addr;
    int dc, ab, pick;
    addr_mode_e mode;
    pick = $urandom_range(0, 9);
    rk = (pick == 0) ? REC_HEADER : (pick < 4) ? REC_S1 : (pick < 7) ? REC_S2 : REC_S3;
    dc = ($urandom_range(0, 4) == 0) ? 16 * $urandom_range(0, 1) : $urandom_range(0, 16);
    ab = addr_len(rk);
    mode = addr_mode_e'($urandom_range(0, 4));
    case (mode)
      ADDR_ANY:        addr = $urandom;
      ADDR_NEAR_START: addr = win_start + $urandom_range(0, 64);
      ADDR_AT_END:     addr = win_end - dc - $urandom_range(0, 3);
      ADDR_PAST_END:   addr = win_end - dc + 1;
      default:         addr = win_start - 1;
    endcase
    if (ab < 4) addr = addr & ((32'd1 << (8 * ab)) - 1);
    src_quiet = ($urandom_range(0, 4) == 0);
    build_record(rk, addr, dc, -1, line_end_e'($urandom_range(0, 2)));
    send_part(pending_chars.size());
  endtask

  task automatic test_directed();
    // reset window: zero byte at the bottom, 0xFF at the last address that still fits
    build_record(REC_S1, 32'h0000, 1, 8'h00, END_LF);
    build_record(REC_S3, 32'hFFFF_FFFE, 1, 8'hFF, END_LF);
    send_part(pending_chars.size());
  endtask

  task automatic test_window_phases();
    logic [31:0] s, e, o;
    int first;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin s = 32'h0; e = 32'hFFFF_FFFF; o = 32'h0; end
        1: begin s = 32'h1000; e = 32'h1100; o = 32'h8000_0000; end
        2: begin
          s = $urandom_range(0, 32'h0000_F000);
          e = s + $urandom_range(0, 4096);
          o = $urandom;
        end
        3: begin s = 32'h00FF_FF00; e = 32'h0100_0000; o = 32'hFFFF_FFF0; end
        4: begin s = 32'hFFFF_FFFF; e = 32'hFFFF_FFFF; o = 32'hFFFF_FFFF; end
        5: begin s = 32'h0; e = 32'h0; o = $urandom; end
        default: begin
          s = $urandom;
          e = s + $urandom_range(0, 32'h000F_FFFF);
          o = $urandom;
        end
      endcase
      wait_idle();
      write_reg(REG_WINDOW_START, s);
      write_reg(REG_WINDOW_END, e);
      write_reg(REG_DEST_OFFSET, o);
      first = chars_sent;
      while (chars_sent - first < 200) rand_record();
    end
  endtask

  task automatic test_config_mid_record();
    wait_idle();
    write_reg(REG_WINDOW_START, 32'h0);
    write_reg(REG_WINDOW_END, 32'h00FF_FFFF);
    write_reg(REG_DEST_OFFSET, 32'h100);
    src_quiet = 1'b0;
    build_record(REC_S2, 32'h0012_3400 | $urandom_range(0, 255), 6, -1, END_LF);
    // stop after two data bytes; the window was decided at the last address digit
    send_part(4 + 6 + 4);
    wait_idle();
    write_reg(REG_WINDOW_START, $urandom_range(0, 32'h0012_3400));
    write_reg(REG_DEST_OFFSET, $urandom);
    write_reg(REG_WINDOW_END, 32'h0);
    send_part(pending_chars.size());
  endtask

  // The loader halts for good here, so each run takes one stop condition
  task automatic test_stop_conditions();
    stop_case_e which;
    logic [7:0] c;
    logic [3:0] scratch;
    int pick, raw;
    wait_idle();
    write_reg(REG_WINDOW_START, 32'h0);
    write_reg(REG_WINDOW_END, 32'hFFFF_FFFF);
    write_reg(REG_DEST_OFFSET, $urandom);
    src_quiet = 1'b0;
    raw = 0;
    which = stop_case_e'($urandom_range(0, 5));
    case (which)
      STOP_END_RECORD: begin
        pick = $urandom_range(0, 2);
        build_record(pick == 0 ? REC_S9 : pick == 1 ? REC_S8 : REC_S7, $urandom,
                     $urandom_range(0, 3), -1, line_end_e'($urandom_range(0, 2)));
      end
      STOP_NO_S: begin
        build_record(REC_S1, $urandom, 2, -1, END_LF);
        do c = 8'($urandom_range(0, 255)); while (c == CH_S);
        pending_chars[0] = $urandom_range(0, 1) ? CH_LF : c;
      end
      STOP_BAD_TYPE: begin
        build_record(REC_S1, $urandom, 2, -1, END_LF);
        case ($urandom_range(0, 4))
          0: c = "4";
          1: c = "5";
          2: c = "6";
          3: c = CH_LF;
          default:
            do c = 8'($urandom_range(0, 255));
            while ((c >= "0" && c <= "3") || (c >= "7" && c <= "9"));
        endcase
        pending_chars[1] = c;
      end
      STOP_BAD_HEX: begin
        build_record(REC_S1, $urandom, 4, -1, END_LF);
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c, scratch));
        // from the count to the last data digit, so writes may come first
        pending_chars[$urandom_range(2, 15)] = ($urandom_range(0, 3) == 0) ? CH_LF : c;
      end
      STOP_COUNT_LOW: begin
        build_record(REC_S2, $urandom, 0, -1, END_LF);
        raw = $urandom_range(0, 3);
      end
      default: begin
        build_record(REC_S1, $urandom, 16, -1, END_LF);
        raw = $urandom_range(20, 255);
      end
    endcase
    if (which == STOP_COUNT_LOW || which == STOP_COUNT_HIGH) begin
      pending_chars[2] = hex_char(raw[7:4]);
      pending_chars[3] = hex_char(raw[3:0]);
    end
    send_part(pending_chars.size());
    // dropped by the halted loader
    build_record(REC_S1, 32'h0010, 2, -1, END_LF);
    send_part(pending_chars.size());
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_WINDOW_START;
    cfg_data = '0;
    char_chan.valid = 1'b0;
    char_chan.char_in = '0;
    result_chan.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_window_phases();
    test_config_mid_record();
    test_stop_conditions();
    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("srecord_window_loader: match");
    end else begin
      $display("srecord_window_loader: mismatch");
    end
    $finish;
  end

endmodule

>>> srecord_window_loader.f
hdl/srwl_pkg.sv
hdl/srwl_if.sv
hdl/srwl_parser.sv
hdl/srecord_window_loader.sv
tb/srecord_window_loader_tb.sv
